### rtl/tre_pkg.sv
// Shared types and constants of the timed register write encoder.
package tre_pkg;

	// Field widths.
	localparam int OP_W      = 2;
	localparam int ADDR_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int WAIT_OP_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Sample rate conversion: elapsed cycles times 44100, with 22 fraction bits.
	localparam int RATE_W = 16;
	localparam logic [RATE_W-1:0] SAMPLE_RATE = 16'd44100;
	localparam int FRAC_W = 22;
	localparam int LO_W   = 24;

	// Wait chunking and clamp.
	localparam int MAX_WAIT_CHUNKS = 60;
	localparam int CHUNK_MAX   = 65535;
	localparam int SHORT_LIMIT = 17;
	localparam int WAIT_LIMIT  = MAX_WAIT_CHUNKS * CHUNK_MAX;
	localparam int WAIT_W      = $clog2(WAIT_LIMIT + 1);

	// Command bytes.
	localparam logic [BYTE_W-1:0] CMD_WAIT_LONG  = 8'h61;
	localparam logic [BYTE_W-1:0] CMD_WAIT_SHORT = 8'h70;
	localparam logic [BYTE_W-1:0] CMD_END        = 8'h66;
	localparam logic [BYTE_W-1:0] CMD_WRITE      = 8'hb3;

	// Register map.
	localparam logic [ADDR_W-1:0] REG_BASE        = 16'hff10;
	localparam logic [BYTE_W-1:0] OFF_MASTER      = 8'h16;
	localparam logic [BYTE_W-1:0] OFF_PANNING     = 8'h15;
	localparam logic [BYTE_W-1:0] OFF_VOLUME      = 8'h14;
	localparam logic [BYTE_W-1:0] MASTER_ON_VALUE = 8'h80;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_PANNING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL    = 2'd2;
	localparam logic [BYTE_W-1:0]    PANNING_RST = 8'hf3;
	localparam logic [BYTE_W-1:0]    VOLUME_RST  = 8'h77;
	localparam logic [WAIT_OP_W-1:0] TAIL_RST    = 16'd44100;

	// Item operations.
	typedef enum logic [OP_W-1:0] {
		OP_ACCESS = 2'd0,
		OP_END    = 2'd1,
		OP_START  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_WAIT,
		ST_WRITE,
		ST_INIT_MASTER,
		ST_INIT_PAN,
		ST_INIT_VOL,
		ST_TAIL,
		ST_END
	} state_t;

	// Kind of command loaded into the output register.
	typedef enum logic [2:0] {
		EMIT_WAIT,
		EMIT_WRITE,
		EMIT_INIT_MASTER,
		EMIT_INIT_PAN,
		EMIT_INIT_VOL,
		EMIT_TAIL,
		EMIT_END
	} emit_kind_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic       load_item;
		logic       clear_time;
		logic       mul_en;
		logic       acc_en;
		logic       emit;
		emit_kind_t kind;
		logic       last;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_free;
		logic rem_zero;
		logic rem_fits;
		logic addr_hit;
	} stat_t;

endpackage

### rtl/tre_ctrl.sv
// Controller state machine of the timed register write encoder.
module tre_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic [tre_pkg::OP_W-1:0]     op,
	input  tre_pkg::stat_t               stat,
	output tre_pkg::ctl_t                ctl,
	output logic                         item_stall
);
	import tre_pkg::*;

	state_t state_q;
	state_t state_next;
	op_t    op_in;

	assign op_in = op_t'(op);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					unique case (op_in)
						OP_ACCESS: state_next = ST_MUL;
						OP_END:    state_next = ST_TAIL;
						OP_START:  state_next = ST_INIT_MASTER;
						default:   state_next = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_next = ST_ACC;
			ST_ACC: state_next = ST_WAIT;
			ST_WAIT: begin
				if (stat.rem_zero || (stat.out_free && stat.rem_fits)) begin
					state_next = stat.addr_hit ? ST_WRITE : ST_IDLE;
				end
			end
			ST_WRITE: begin
				if (stat.out_free) state_next = ST_IDLE;
			end
			ST_INIT_MASTER: begin
				if (stat.out_free) state_next = ST_INIT_PAN;
			end
			ST_INIT_PAN: begin
				if (stat.out_free) state_next = ST_INIT_VOL;
			end
			ST_INIT_VOL: begin
				if (stat.out_free) state_next = ST_IDLE;
			end
			ST_TAIL: begin
				if (stat.out_free) state_next = ST_END;
			end
			ST_END: begin
				if (stat.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctl        = '0;
		ctl.kind   = EMIT_WAIT;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				ctl.load_item  = item_valid;
				ctl.clear_time = item_valid && (op_in == OP_START);
			end
			ST_MUL: ctl.mul_en = 1'b1;
			ST_ACC: ctl.acc_en = 1'b1;
			ST_WAIT: begin
				ctl.emit = stat.out_free && !stat.rem_zero;
				ctl.kind = EMIT_WAIT;
				ctl.last = stat.rem_fits && !stat.addr_hit;
			end
			ST_WRITE: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_WRITE;
				ctl.last = 1'b1;
			end
			ST_INIT_MASTER: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_INIT_MASTER;
			end
			ST_INIT_PAN: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_INIT_PAN;
			end
			ST_INIT_VOL: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_INIT_VOL;
				ctl.last = 1'b1;
			end
			ST_TAIL: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_TAIL;
			end
			ST_END: begin
				ctl.emit = stat.out_free;
				ctl.kind = EMIT_END;
				ctl.last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### rtl/tre_dp.sv
// Datapath of the timed register write encoder: timing, wait chunking and output register.
module tre_dp #(
	parameter int CYCLE_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tre_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic [47:0]                     cycle_count,
	input  logic [tre_pkg::ADDR_W-1:0]      bus_address,
	input  logic [tre_pkg::BYTE_W-1:0]      write_data,
	input  tre_pkg::ctl_t                   ctl,
	output tre_pkg::stat_t                  stat,
	input  logic                            cmd_stall,
	output logic                            cmd_valid,
	output logic [tre_pkg::BYTE_W-1:0]      command,
	output logic [tre_pkg::WAIT_OP_W-1:0]   wait_samples,
	output logic [tre_pkg::BYTE_W-1:0]      reg_offset,
	output logic [tre_pkg::BYTE_W-1:0]      reg_value,
	output logic                            clamped,
	output logic                            last
);
	import tre_pkg::*;

	localparam int HI_W    = CYCLE_BITS - LO_W;
	localparam int PLO_W   = LO_W + RATE_W;
	localparam int PHI_W   = HI_W + RATE_W;
	localparam int ACC_W   = CYCLE_BITS + RATE_W;
	localparam int WHOLE_W = ACC_W - FRAC_W;

	// Configuration registers.
	logic [BYTE_W-1:0]    panning_q;
	logic [BYTE_W-1:0]    volume_q;
	logic [WAIT_OP_W-1:0] tail_q;

	// Timing state.
	logic [CYCLE_BITS-1:0] prev_q;
	logic [FRAC_W-1:0]     frac_q;

	// Current item.
	logic [CYCLE_BITS-1:0] cyc_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BYTE_W-1:0]     data_q;

	// Multiply stage and wait counter.
	logic [PLO_W-1:0]  pp_lo_s1;
	logic [PHI_W-1:0]  pp_hi_s1;
	logic              ge_s1;
	logic [WAIT_W-1:0] rem_q;
	logic              clamp_q;

	// Output register.
	logic                 valid_q;
	logic [BYTE_W-1:0]    command_q;
	logic [WAIT_OP_W-1:0] wait_q;
	logic [BYTE_W-1:0]    offset_q;
	logic [BYTE_W-1:0]    value_q;
	logic                 clamped_q;
	logic                 last_q;

	logic [CYCLE_BITS-1:0] delta;
	logic [PLO_W-1:0]      lo_ext;
	logic [PHI_W-1:0]      hi_ext;
	logic [ACC_W-1:0]      acc;
	logic [WHOLE_W-1:0]    whole;
	logic                  over;
	logic                  rem_short;
	logic                  rem_fits;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panning_q <= PANNING_RST;
			volume_q  <= VOLUME_RST;
			tail_q    <= TAIL_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PANNING) panning_q <= cfg_data[BYTE_W-1:0];
			if (cfg_index == CFG_VOLUME)  volume_q  <= cfg_data[BYTE_W-1:0];
			if (cfg_index == CFG_TAIL)    tail_q    <= cfg_data[WAIT_OP_W-1:0];
		end
	end

	// Item capture at acceptance.
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cyc_q  <= cycle_count[CYCLE_BITS-1:0];
			addr_q <= bus_address;
			data_q <= write_data;
		end
	end

	// Elapsed cycles times the sample rate, as two registered partial products.
	assign delta  = cyc_q - prev_q;
	assign lo_ext = PLO_W'(delta[LO_W-1:0]);
	assign hi_ext = PHI_W'(delta[CYCLE_BITS-1:LO_W]);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			pp_lo_s1 <= lo_ext * PLO_W'(SAMPLE_RATE);
			pp_hi_s1 <= hi_ext * PHI_W'(SAMPLE_RATE);
			ge_s1    <= (cyc_q >= prev_q);
		end
	end

	// Sum with the carried fraction, split whole samples and clamp.
	assign acc   = ACC_W'({pp_hi_s1, {LO_W{1'b0}}}) + ACC_W'(pp_lo_s1) + ACC_W'(frac_q);
	assign whole = acc[ACC_W-1:FRAC_W];
	assign over  = ge_s1 && (whole > WHOLE_W'(WAIT_LIMIT));

	// Timing state: cleared by a start, advanced by an access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			frac_q <= '0;
		end else if (ctl.clear_time) begin
			prev_q <= '0;
			frac_q <= '0;
		end else if (ctl.acc_en) begin
			prev_q <= cyc_q;
			if (ge_s1) frac_q <= acc[FRAC_W-1:0];
		end
	end

	// Wait chunking.
	assign rem_short = (rem_q < WAIT_W'(SHORT_LIMIT));
	assign rem_fits  = (rem_q <= WAIT_W'(CHUNK_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			clamp_q <= 1'b0;
		end else if (ctl.acc_en) begin
			clamp_q <= over;
			if (!ge_s1) begin
				rem_q <= '0;
			end else if (over) begin
				rem_q <= WAIT_W'(WAIT_LIMIT);
			end else begin
				rem_q <= whole[WAIT_W-1:0];
			end
		end else if (ctl.emit && (ctl.kind == EMIT_WAIT)) begin
			rem_q <= rem_fits ? '0 : (rem_q - WAIT_W'(CHUNK_MAX));
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.emit) begin
			valid_q <= 1'b1;
		end else if (!cmd_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			wait_q    <= '0;
			offset_q  <= '0;
			value_q   <= '0;
			clamped_q <= 1'b0;
			last_q    <= ctl.last;
			unique case (ctl.kind)
				EMIT_WAIT: begin
					clamped_q <= clamp_q;
					if (rem_short) begin
						command_q <= CMD_WAIT_SHORT | {4'h0, 4'(rem_q[3:0] - 4'd1)};
					end else begin
						command_q <= CMD_WAIT_LONG;
						wait_q    <= rem_fits ? rem_q[WAIT_OP_W-1:0] : WAIT_OP_W'(CHUNK_MAX);
					end
				end
				EMIT_WRITE: begin
					command_q <= CMD_WRITE;
					offset_q  <= BYTE_W'(addr_q - REG_BASE);
					value_q   <= data_q;
					clamped_q <= clamp_q;
				end
				EMIT_INIT_MASTER: begin
					command_q <= CMD_WRITE;
					offset_q  <= OFF_MASTER;
					value_q   <= MASTER_ON_VALUE;
				end
				EMIT_INIT_PAN: begin
					command_q <= CMD_WRITE;
					offset_q  <= OFF_PANNING;
					value_q   <= panning_q;
				end
				EMIT_INIT_VOL: begin
					command_q <= CMD_WRITE;
					offset_q  <= OFF_VOLUME;
					value_q   <= volume_q;
				end
				EMIT_TAIL: begin
					command_q <= CMD_WAIT_LONG;
					wait_q    <= tail_q;
				end
				EMIT_END: command_q <= CMD_END;
				default: command_q <= CMD_END;
			endcase
		end
	end

	// Status to the controller.
	assign stat.out_free = !valid_q || !cmd_stall;
	assign stat.rem_zero = (rem_q == '0);
	assign stat.rem_fits = rem_fits;
	assign stat.addr_hit = (addr_q >= REG_BASE);

	assign cmd_valid    = valid_q;
	assign command      = command_q;
	assign wait_samples = wait_q;
	assign reg_offset   = offset_q;
	assign reg_value    = value_q;
	assign clamped      = clamped_q;
	assign last         = last_q;

endmodule

### rtl/timed_register_write_encoder_top.sv
// An access item passes the multiply, sum and chunk states before its first command is loaded;
// with no wait its write comes from the write state, and with no wait and an address below the
// register base it loads none. Start and end items load their first command from the state
// entered at acceptance. Each command waits for a free output register, so output stalls hold it.
// A new item is taken once the previous one has loaded its last command, even while it waits.
// Reset (arst_n low) clears timing and handshake state and restores the register defaults.
module timed_register_write_encoder_top #(
	parameter int CYCLE_BITS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tre_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [tre_pkg::OP_W-1:0]        op,
	input  logic [47:0]                     cycle_count,
	input  logic [tre_pkg::ADDR_W-1:0]      bus_address,
	input  logic [tre_pkg::BYTE_W-1:0]      write_data,
	output logic                            cmd_valid,
	input  logic                            cmd_stall,
	output logic [tre_pkg::BYTE_W-1:0]      command,
	output logic [tre_pkg::WAIT_OP_W-1:0]   wait_samples,
	output logic [tre_pkg::BYTE_W-1:0]      reg_offset,
	output logic [tre_pkg::BYTE_W-1:0]      reg_value,
	output logic                            clamped,
	output logic                            last
);
	import tre_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	// Sequencing of each item.
	tre_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.op         (op),
		.stat       (stat),
		.ctl        (ctl),
		.item_stall (item_stall)
	);

	// Timing arithmetic and command formation.
	tre_dp #(
		.CYCLE_BITS (CYCLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cycle_count  (cycle_count),
		.bus_address  (bus_address),
		.write_data   (write_data),
		.ctl          (ctl),
		.stat         (stat),
		.cmd_stall    (cmd_stall),
		.cmd_valid    (cmd_valid),
		.command      (command),
		.wait_samples (wait_samples),
		.reg_offset   (reg_offset),
		.reg_value    (reg_value),
		.clamped      (clamped),
		.last         (last)
	);

endmodule

### test/timed_register_write_encoder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed register write encoder top level.
module timed_register_write_encoder_top_test;
	import tre_pkg::*;

	localparam int SETTLE_CYCLES = 20;
	localparam int SEGMENTS      = 6;
	localparam int SEGMENT_ITEMS = 50;

	// One emitted command as seen on the output port.
	typedef struct packed {
		logic [BYTE_W-1:0]    command;
		logic [WAIT_OP_W-1:0] wait_samples;
		logic [BYTE_W-1:0]    reg_offset;
		logic [BYTE_W-1:0]    reg_value;
		logic                 clamped;
		logic                 last;
	} cmd_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 item_valid;
	logic                 item_stall;
	logic [OP_W-1:0]      op;
	logic [47:0]          cycle_count;
	logic [ADDR_W-1:0]    bus_address;
	logic [BYTE_W-1:0]    write_data;
	logic                 cmd_valid;
	logic                 cmd_stall;
	logic [BYTE_W-1:0]    command;
	logic [WAIT_OP_W-1:0] wait_samples;
	logic [BYTE_W-1:0]    reg_offset;
	logic [BYTE_W-1:0]    reg_value;
	logic                 clamped;
	logic                 last;

	// Predictor state and its copy of the configuration.
	logic [47:0]          last_cycles;
	logic [FRAC_W-1:0]    sample_frac;
	logic [BYTE_W-1:0]    panning_cfg;
	logic [BYTE_W-1:0]    volume_cfg;
	logic [WAIT_OP_W-1:0] tail_cfg;
	cmd_rec_t             pending_cmds[$];

	// Stimulus state and run statistics.
	logic [47:0] stream_time;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          hold_request = 0;
	int          error_count = 0;
	int          items_sent = 0;
	int          starts_sent = 0;
	int          ends_sent = 0;
	int          accesses_sent = 0;
	int          cmds_checked = 0;
	int          clamped_seen = 0;

	timed_register_write_encoder_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.cycle_count (cycle_count),
		.bus_address (bus_address),
		.write_data  (write_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.wait_samples(wait_samples),
		.reg_offset  (reg_offset),
		.reg_value   (reg_value),
		.clamped     (clamped),
		.last        (last)
	);

	always #1 clk = ~clk;

	function automatic cmd_rec_t make_cmd(logic [BYTE_W-1:0] code, logic [WAIT_OP_W-1:0] samples,
			logic [BYTE_W-1:0] offset, logic [BYTE_W-1:0] value, logic clip);
		cmd_rec_t rec;
		rec.command      = code;
		rec.wait_samples = samples;
		rec.reg_offset   = offset;
		rec.reg_value    = value;
		rec.clamped      = clip;
		rec.last         = 1'b0;
		return rec;
	endfunction

	// Works out the commands one accepted item produces and queues them in order.
	function automatic void encode_item(op_t kind, logic [47:0] cyc, logic [ADDR_W-1:0] addr,
			logic [BYTE_W-1:0] data);
		cmd_rec_t   batch[$];
		cmd_rec_t   final_rec;
		logic [63:0] acc;
		logic [63:0] whole;
		logic       clip;
		whole = '0;
		clip  = 1'b0;
		case (kind)
		OP_START: begin
			last_cycles = '0;
			sample_frac = '0;
			batch.push_back(make_cmd(CMD_WRITE, '0, OFF_MASTER, MASTER_ON_VALUE, 1'b0));
			batch.push_back(make_cmd(CMD_WRITE, '0, OFF_PANNING, panning_cfg, 1'b0));
			batch.push_back(make_cmd(CMD_WRITE, '0, OFF_VOLUME, volume_cfg, 1'b0));
		end
		OP_END: begin
			batch.push_back(make_cmd(CMD_WAIT_LONG, tail_cfg, '0, '0, 1'b0));
			batch.push_back(make_cmd(CMD_END, '0, '0, '0, 1'b0));
		end
		OP_ACCESS: begin
			// Time running backward keeps the fraction and emits no wait.
			if (cyc >= last_cycles) begin
				acc = (64'(cyc) - 64'(last_cycles)) * 64'(SAMPLE_RATE) + 64'(sample_frac);
				whole = acc >> FRAC_W;
				sample_frac = acc[FRAC_W-1:0];
			end
			last_cycles = cyc;
			if (whole > 64'(WAIT_LIMIT)) begin
				whole = 64'(WAIT_LIMIT);
				clip  = 1'b1;
			end
			// Split the whole samples into short and long wait commands.
			while (whole > 0) begin
				if (whole < SHORT_LIMIT) begin
					batch.push_back(make_cmd(CMD_WAIT_SHORT | 8'(whole - 1), '0, '0, '0, clip));
					whole = '0;
				end else if (whole > CHUNK_MAX) begin
					batch.push_back(make_cmd(CMD_WAIT_LONG, 16'(CHUNK_MAX), '0, '0, clip));
					whole = whole - CHUNK_MAX;
				end else begin
					batch.push_back(make_cmd(CMD_WAIT_LONG, whole[15:0], '0, '0, clip));
					whole = '0;
				end
			end
			if (addr >= REG_BASE)
				batch.push_back(make_cmd(CMD_WRITE, '0, 8'(addr - REG_BASE), data, clip));
		end
		default: ;
		endcase
		if (batch.size() > 0) begin
			final_rec = batch[batch.size()-1];
			final_rec.last = 1'b1;
			batch[batch.size()-1] = final_rec;
		end
		foreach (batch[k])
			pending_cmds.push_back(batch[k]);
	endfunction

	function automatic void check_field(string name, logic [15:0] expected, logic [15:0] actual);
		if (actual !== expected) begin
			$error("%s mismatch: expected %h, got %h", name, expected, actual);
			error_count++;
		end
	endfunction

	// Compare every accepted command with the oldest pending one.
	always @(posedge clk) begin : cmd_checker
		cmd_rec_t exp_cmd;
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (pending_cmds.size() == 0) begin
				$error("command %h arrived with nothing pending", command);
				error_count++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				check_field("command", exp_cmd.command, command);
				check_field("wait_samples", exp_cmd.wait_samples, wait_samples);
				check_field("reg_offset", exp_cmd.reg_offset, reg_offset);
				check_field("reg_value", exp_cmd.reg_value, reg_value);
				check_field("clamped", exp_cmd.clamped, clamped);
				check_field("last", exp_cmd.last, last);
				cmds_checked++;
				if (clamped)
					clamped_seen++;
			end
		end
	end

	// Receiver stall: random bursts, or one long hold when a test asks for it.
	initial begin : rx_stall_gen
		int stall_left;
		stall_left = 0;
		cmd_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8);
			end
			if (stall_left > 0) begin
				cmd_stall <= 1'b1;
				stall_left--;
			end else begin
				cmd_stall <= 1'b0;
			end
		end
	end

	// Offers one item, with an optional idle burst first, and predicts it on acceptance.
	task automatic send_item(input op_t kind, input logic [47:0] cyc, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data);
		int gap;
		gap = 0;
		if (tx_idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid  <= 1'b1;
		op          <= kind;
		cycle_count <= cyc;
		bus_address <= addr;
		write_data  <= data;
		do @(posedge clk); while (item_stall);
		encode_item(kind, cyc, addr, data);
		items_sent++;
		case (kind)
		OP_START: starts_sent++;
		OP_END: ends_sent++;
		OP_ACCESS: accesses_sent++;
		default: ;
		endcase
	endtask

	// Drops valid, waits for every pending command, then lets the block settle.
	task automatic drain_commands();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_cmds.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
		CFG_PANNING: panning_cfg = value[BYTE_W-1:0];
		CFG_VOLUME: volume_cfg = value[BYTE_W-1:0];
		CFG_TAIL: tail_cfg = value;
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_start();
		stream_time = '0;
		send_item(OP_START, {16'($urandom), 32'($urandom)}, 16'($urandom), 8'($urandom));
	endtask

	task automatic send_access(input logic [47:0] cyc, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data);
		stream_time = cyc;
		send_item(OP_ACCESS, cyc, addr, data);
	endtask

	// Sample boundaries, wait forms, backward time, clamping and the unused op.
	task automatic test_directed_timing();
		send_start();
		send_access(48'd0, REG_BASE, 8'h00);
		send_access(48'd96, 16'hffff, 8'hff);
		send_start();
		// 16 samples is the longest short wait, 17 the shortest long one.
		send_access(48'd1522, 16'hff26, 8'h5a);
		send_access(48'd3139, 16'h0000, 8'ha5);
		send_access(48'd3234, 16'hff0f, 8'h3c);
		send_access(48'd6303139, 16'hff20, 8'h81);
		send_access(48'd100, 16'hff11, 8'h7e);
		send_access(48'hffff_ffff_ffff, 16'hff12, 8'h01);
		send_access(48'd0, 16'hff0f, 8'hff);
		send_item(OP_END, 48'd0, 16'h0000, 8'h00);
		send_item(OP_NONE, 48'hffff_ffff_ffff, 16'hffff, 8'hff);
		// Exactly the wait limit, then one sample beyond it.
		send_start();
		send_access(48'd373977841, 16'hff30, 8'hc3);
		send_start();
		send_access(48'd373977937, 16'hff30, 8'h3c);
		send_item(OP_END, 48'hffff_ffff_ffff, 16'hffff, 8'hff);
		drain_commands();
	endtask

	// Extreme register settings seen through the start and end sequences.
	task automatic test_config_settings();
		cfg_write(CFG_PANNING, 16'h0000);
		cfg_write(CFG_VOLUME, 16'hffff);
		cfg_write(CFG_TAIL, 16'h0000);
		send_start();
		send_item(OP_END, 48'd0, 16'h0000, 8'h00);
		drain_commands();
		cfg_write(CFG_PANNING, 16'hffff);
		cfg_write(CFG_VOLUME, 16'h0000);
		cfg_write(CFG_TAIL, 16'hffff);
		send_start();
		send_item(OP_END, 48'd0, 16'h0000, 8'h00);
		drain_commands();
	endtask

	// The receiver holds off while multi-chunk accesses keep coming, so the input stalls.
	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		hold_request = 300;
		send_start();
		repeat (8)
			send_access(stream_time + $urandom_range(12000000, 30000000),
				REG_BASE + 16'($urandom_range(0, 47)), 8'($urandom));
		drain_commands();
		tx_idle_on = 1'b1;
	endtask

	task automatic send_random_access();
		logic [47:0]       cyc;
		logic [ADDR_W-1:0] addr;
		int                pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			cyc = stream_time + $urandom_range(0, 2000);
		else if (pick < 72)
			cyc = stream_time + $urandom_range(2001, 200000);
		else if (pick < 84)
			cyc = stream_time + $urandom_range(200001, 40000000);
		else if (pick < 87)
			cyc = {16'($urandom), 32'($urandom)};
		else if (pick < 94)
			cyc = stream_time - $urandom_range(1, 5000);
		else
			cyc = stream_time;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			addr = REG_BASE + 16'($urandom_range(0, 47));
		else if (pick == 7)
			addr = 16'($urandom);
		else
			addr = REG_BASE + 16'($urandom_range(0, 239));
		send_access(cyc, addr, 8'($urandom));
	endtask

	function automatic logic [CFG_DAT_W-1:0] random_cfg_value();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
		return 16'($urandom);
	endfunction

	// Random streams in segments, with new settings between them; the last one runs flat out.
	task automatic test_random_streams();
		int pick;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			cfg_write(CFG_PANNING, random_cfg_value());
			cfg_write(CFG_VOLUME, random_cfg_value());
			cfg_write(CFG_TAIL, random_cfg_value());
			tx_idle_on = (seg < SEGMENTS - 1) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (seg < SEGMENTS - 1) && ($urandom_range(0, 3) != 0);
			send_start();
			for (int i = 1; i < SEGMENT_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					send_start();
				else if (pick < 8)
					send_item(OP_END, {16'($urandom), 32'($urandom)}, 16'($urandom), 8'($urandom));
				else if (pick < 10)
					send_item(OP_NONE, {16'($urandom), 32'($urandom)}, 16'($urandom),
						8'($urandom));
				else
					send_random_access();
			end
			drain_commands();
		end
	endtask

	// Reset, run each test in turn, then report.
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		item_valid  = 1'b0;
		op          = '0;
		cycle_count = '0;
		bus_address = '0;
		write_data  = '0;
		last_cycles = '0;
		sample_frac = '0;
		panning_cfg = PANNING_RST;
		volume_cfg  = VOLUME_RST;
		tail_cfg    = TAIL_RST;
		stream_time = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_timing();
		test_config_settings();
		test_output_backpressure();
		test_random_streams();
		$display("Sent %0d items: %0d stream starts, %0d ends, %0d register accesses.",
			items_sent, starts_sent, ends_sent, accesses_sent);
		$display("Checked %0d commands, %0d of them from clamped delays.",
			cmds_checked, clamped_seen);
		if (error_count == 0) begin
			$display("timed_register_write_encoder_top verification clean");
		end else begin
			$display("timed_register_write_encoder_top verification failed");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#2000000;
		$display("timed_register_write_encoder_top verification failed");
		$finish;
	end

endmodule
